FILE: rtl/rgbnv_pkg.sv
// ----------------------------------------------------------------------------
// rgbnv_pkg
// shared types, constants and color math for the rgb to nv12 converter
// ----------------------------------------------------------------------------
package rgbnv_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int CHAN_W      = 8;
  localparam int SIZE_W      = 12;
  localparam int PAIR_W      = 9;
  localparam int STORE_W     = 2 * PAIR_W;
  localparam int CFG_INDEX_W = 2;

  localparam logic [SIZE_W-1:0] FRAME_SIZE_RESET = SIZE_W'(2048);

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_ORDER   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = CFG_INDEX_W'(2);

  // position flags of one pixel in the raster
  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic last;
  } raster_info_t;

  // bt.709 limited range, 8-bit fixed-point weights; sums never leave 0..65535
  function automatic logic [CHAN_W-1:0] luma_of(input logic [CHAN_W-1:0] r,
                                                input logic [CHAN_W-1:0] g,
                                                input logic [CHAN_W-1:0] b);
    logic [15:0] acc;
    begin
      acc = 16'd47 * 16'(r) + 16'd157 * 16'(g) + 16'd16 * 16'(b) + 16'd128;
      return CHAN_W'(16) + acc[15:8];
    end
  endfunction

  // 32896 = 128 rounding plus 128 << 8 offset
  function automatic logic [CHAN_W-1:0] cb_of(input logic [CHAN_W-1:0] r,
                                              input logic [CHAN_W-1:0] g,
                                              input logic [CHAN_W-1:0] b);
    logic [15:0] acc;
    begin
      acc = 16'd32896 + 16'd112 * 16'(b) - 16'd26 * 16'(r) - 16'd87 * 16'(g);
      return acc[15:8];
    end
  endfunction

  function automatic logic [CHAN_W-1:0] cr_of(input logic [CHAN_W-1:0] r,
                                              input logic [CHAN_W-1:0] g,
                                              input logic [CHAN_W-1:0] b);
    logic [15:0] acc;
    begin
      acc = 16'd32896 + 16'd112 * 16'(r) - 16'd102 * 16'(g) - 16'd10 * 16'(b);
      return acc[15:8];
    end
  endfunction

endpackage

FILE: rtl/rgbnv_line_store.sv
// ----------------------------------------------------------------------------
// rgbnv_line_store
// chroma pair-sum line memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rgbnv_line_store #(
  parameter int DEPTH = rgbnv_pkg::MAX_WIDTH_DEF / 2,
  parameter int AW    = 10
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [rgbnv_pkg::STORE_W-1:0] rd_data,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [rgbnv_pkg::STORE_W-1:0] wr_data
);

  logic [rgbnv_pkg::STORE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // same-cycle write to the read address is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

FILE: rtl/rgbnv_raster.sv
// ----------------------------------------------------------------------------
// rgbnv_raster
// column and row counters with clamped even frame size
// ----------------------------------------------------------------------------
module rgbnv_raster #(
  parameter int MAX_WIDTH  = rgbnv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbnv_pkg::MAX_HEIGHT_DEF,
  parameter int AW         = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic [rgbnv_pkg::SIZE_W-1:0]     frame_width,
  input  logic [rgbnv_pkg::SIZE_W-1:0]     frame_height,
  output logic [AW-1:0]                    pair_index,
  output rgbnv_pkg::raster_info_t          info
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int XEW = ($clog2(MAX_WIDTH + 1) > rgbnv_pkg::SIZE_W) ?
                       $clog2(MAX_WIDTH + 1) : rgbnv_pkg::SIZE_W;
  localparam int YEW = ($clog2(MAX_HEIGHT + 1) > rgbnv_pkg::SIZE_W) ?
                       $clog2(MAX_HEIGHT + 1) : rgbnv_pkg::SIZE_W;

  logic [XW-1:0]  column_count;
  logic [YW-1:0]  row_count;
  logic [XEW-1:0] width_eff;
  logic [YEW-1:0] height_eff;
  logic [XEW-1:0] column_plus;
  logic [YEW-1:0] row_plus;
  logic           column_last;
  logic           row_last;

  // clamp to 2..max and force even
  always_comb begin
    width_eff = XEW'(frame_width);
    if (width_eff > XEW'(MAX_WIDTH)) begin
      width_eff = XEW'(MAX_WIDTH);
    end
    if (width_eff < XEW'(2)) begin
      width_eff = XEW'(2);
    end
    width_eff[0] = 1'b0;

    height_eff = YEW'(frame_height);
    if (height_eff > YEW'(MAX_HEIGHT)) begin
      height_eff = YEW'(MAX_HEIGHT);
    end
    if (height_eff < YEW'(2)) begin
      height_eff = YEW'(2);
    end
    height_eff[0] = 1'b0;
  end

  assign column_plus = XEW'(column_count) + XEW'(1);
  assign row_plus    = YEW'(row_count) + YEW'(1);
  assign column_last = column_plus >= width_eff;
  assign row_last    = row_plus >= height_eff;

  assign pair_index   = AW'(column_count >> 1);
  assign info.odd_col = column_count[0];
  assign info.odd_row = row_count[0];
  assign info.last    = column_last && row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      if (column_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : YW'(row_plus);
      end else begin
        column_count <= XW'(column_plus);
      end
    end
  end

endmodule

FILE: rtl/rgb_to_nv12_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_nv12_converter
// rgb pixel stream to bt.709 limited-range luma and 2x2 averaged chroma
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   --------  ---------  -----------------  -----------------------------------
//   in        sink       in_valid/in_stall  channel_a, channel_b, channel_c
//   out       source     out_valid/out_stall luma, chroma_valid, chroma_u,
//                                           chroma_v, frame_end
//   cfg       sink       cfg_write          cfg_index, cfg_data
//
// one pixel per clock sustained while out_stall is low; a beat reaches the
// output through three registers (input register with line store read, color
// math, output register); the line store is read when a pixel is taken and
// written when an even-row pixel at an odd column leaves the color stage; a
// same-cycle hit is forwarded inside the store
// rst clears counters, stage valids and config; the line store is not cleared
// out_stall holds only the stages that are full, so bubbles close up and
// in_stall rises only when every stage holds a beat
//
module rgb_to_nv12_converter #(
  parameter int MAX_WIDTH  = rgbnv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbnv_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // config
  input  logic                                cfg_write,
  input  logic [rgbnv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rgbnv_pkg::SIZE_W-1:0]        cfg_data,
  // pixel in
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rgbnv_pkg::CHAN_W-1:0]        channel_a,
  input  logic [rgbnv_pkg::CHAN_W-1:0]        channel_b,
  input  logic [rgbnv_pkg::CHAN_W-1:0]        channel_c,
  // pixel out
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rgbnv_pkg::CHAN_W-1:0]        luma,
  output logic                                chroma_valid,
  output logic [rgbnv_pkg::CHAN_W-1:0]        chroma_u,
  output logic [rgbnv_pkg::CHAN_W-1:0]        chroma_v,
  output logic                                frame_end
);

  localparam int DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = rgbnv_pkg::CHAN_W;
  localparam int PW    = rgbnv_pkg::PAIR_W;
  localparam int SW    = rgbnv_pkg::STORE_W;

  // config registers
  logic                            byte_order;
  logic [rgbnv_pkg::SIZE_W-1:0]    frame_width;
  logic [rgbnv_pkg::SIZE_W-1:0]    frame_height;

  // handshake and stage moves
  logic accept;
  logic out_load;
  logic s1_free;
  logic s1_move;
  logic s2_free;
  logic s2_move;

  // raster position of the incoming pixel
  logic [AW-1:0]            pair_index;
  rgbnv_pkg::raster_info_t  raster_info;

  // stage 1: input register, line store read in flight
  logic                     s1_valid;
  logic [CW-1:0]            s1_r;
  logic [CW-1:0]            s1_g;
  logic [CW-1:0]            s1_b;
  logic [AW-1:0]            s1_index;
  rgbnv_pkg::raster_info_t  s1_info;
  logic [SW-1:0]            store_rd_data;

  // stage 2: converted color
  logic                     s2_valid;
  logic [CW-1:0]            s2_luma;
  logic [CW-1:0]            s2_u;
  logic [CW-1:0]            s2_v;
  logic [AW-1:0]            s2_index;
  rgbnv_pkg::raster_info_t  s2_info;
  logic [SW-1:0]            s2_line;

  // u in the low byte, v in the high byte
  logic [2*CW-1:0]          even_column_chroma;

  // chroma sums
  logic [PW-1:0]            pair_u;
  logic [PW-1:0]            pair_v;
  logic [PW:0]              quad_u;
  logic [PW:0]              quad_v;
  logic                     store_wr_en;

  // ---------------------------------------------------------------------------
  // config port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_order   <= 1'b0;
      frame_width  <= rgbnv_pkg::FRAME_SIZE_RESET;
      frame_height <= rgbnv_pkg::FRAME_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rgbnv_pkg::REG_BYTE_ORDER:   byte_order   <= cfg_data[0];
        rgbnv_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        rgbnv_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // flow control: each stage moves when the one after it has room
  // ---------------------------------------------------------------------------
  assign out_load = !out_valid || !out_stall;
  assign s2_free  = !s2_valid || out_load;
  assign s2_move  = s2_valid && out_load;
  assign s1_free  = !s1_valid || s2_free;
  assign s1_move  = s1_valid && s2_free;
  assign accept   = in_valid && s1_free;
  assign in_stall = !s1_free;

  // ---------------------------------------------------------------------------
  // raster counters
  // ---------------------------------------------------------------------------
  rgbnv_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_raster (
    .clk          (clk),
    .rst          (rst),
    .advance      (accept),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pair_index   (pair_index),
    .info         (raster_info)
  );

  // ---------------------------------------------------------------------------
  // line store: read on accept, write on even rows at odd columns
  // ---------------------------------------------------------------------------
  assign store_wr_en = s2_move && s2_info.odd_col && !s2_info.odd_row;

  rgbnv_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (pair_index),
    .rd_data (store_rd_data),
    .wr_en   (store_wr_en),
    .wr_addr (s2_index),
    .wr_data ({pair_v, pair_u})
  );

  // ---------------------------------------------------------------------------
  // stage 1: capture pixel, resolve byte order
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r     <= byte_order ? channel_c : channel_a;
      s1_g     <= channel_b;
      s1_b     <= byte_order ? channel_a : channel_c;
      s1_index <= pair_index;
      s1_info  <= raster_info;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: color matrix
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_move;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_luma  <= rgbnv_pkg::luma_of(s1_r, s1_g, s1_b);
      s2_u     <= rgbnv_pkg::cb_of(s1_r, s1_g, s1_b);
      s2_v     <= rgbnv_pkg::cr_of(s1_r, s1_g, s1_b);
      s2_index <= s1_index;
      s2_info  <= s1_info;
      s2_line  <= store_rd_data;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: column pair and 2x2 sums into the output register
  // ---------------------------------------------------------------------------
  assign pair_u = PW'(even_column_chroma[CW-1:0]) + PW'(s2_u);
  assign pair_v = PW'(even_column_chroma[2*CW-1:CW]) + PW'(s2_v);
  assign quad_u = (PW+1)'(pair_u) + (PW+1)'(s2_line[PW-1:0]);
  assign quad_v = (PW+1)'(pair_v) + (PW+1)'(s2_line[SW-1:PW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      even_column_chroma <= '0;
    end else if (s2_move && !s2_info.odd_col) begin
      even_column_chroma <= {s2_v, s2_u};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      luma      <= s2_luma;
      frame_end <= s2_info.last;
      if (s2_info.odd_col && s2_info.odd_row) begin
        chroma_valid <= 1'b1;
        chroma_u     <= quad_u[PW:2];
        chroma_v     <= quad_v[PW:2];
      end else begin
        chroma_valid <= 1'b0;
        chroma_u     <= '0;
        chroma_v     <= '0;
      end
    end
  end

endmodule

FILE: verif/nv12_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nv12_stream_checker
// predicts luma and 2x2 averaged chroma for every pixel beat taken in, and
// compares the beats that come out, in order, field by field
// ----------------------------------------------------------------------------
module nv12_stream_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rgbnv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rgbnv_pkg::SIZE_W-1:0]      cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [rgbnv_pkg::CHAN_W-1:0]      channel_a,
  input  logic [rgbnv_pkg::CHAN_W-1:0]      channel_b,
  input  logic [rgbnv_pkg::CHAN_W-1:0]      channel_c,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [rgbnv_pkg::CHAN_W-1:0]      luma,
  input  logic                              chroma_valid,
  input  logic [rgbnv_pkg::CHAN_W-1:0]      chroma_u,
  input  logic [rgbnv_pkg::CHAN_W-1:0]      chroma_v,
  input  logic                              frame_end,
  output int                                pending_beats,
  output int                                fail_count
);

  localparam int LINE_PAIRS = rgbnv_pkg::MAX_WIDTH_DEF / 2;

  typedef struct {
    logic [rgbnv_pkg::CHAN_W-1:0] luma;
    logic                         chroma_valid;
    logic [rgbnv_pkg::CHAN_W-1:0] chroma_u;
    logic [rgbnv_pkg::CHAN_W-1:0] chroma_v;
    logic                         frame_end;
  } nv12_beat_t;

  logic                          byte_swap;
  logic [rgbnv_pkg::SIZE_W-1:0]  width_reg;
  logic [rgbnv_pkg::SIZE_W-1:0]  height_reg;
  int                            column_pos;
  int                            row_pos;
  logic [15:0]                   left_chroma;
  logic [rgbnv_pkg::STORE_W-1:0] pair_sums [LINE_PAIRS];
  nv12_beat_t                    expected_pixels [$];
  int                            mismatches = 0;

  function automatic int span_of(logic [rgbnv_pkg::SIZE_W-1:0] value, int limit);
    int s;
    s = value;
    if (s > limit) s = limit;
    if (s < 2) s = 2;
    return s & ~1;
  endfunction

  function automatic int clip_byte(int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // one pixel through the converter, advancing the raster position
  function automatic nv12_beat_t convert_pixel(logic [rgbnv_pkg::CHAN_W-1:0] a,
                                               logic [rgbnv_pkg::CHAN_W-1:0] g,
                                               logic [rgbnv_pkg::CHAN_W-1:0] c);
    int r, gr, b, cb, cr, u_sum, v_sum, w, h;
    logic [rgbnv_pkg::STORE_W-1:0] sums;
    nv12_beat_t beat;
    r  = byte_swap ? int'(c) : int'(a);
    gr = int'(g);
    b  = byte_swap ? int'(a) : int'(c);
    w  = span_of(width_reg, rgbnv_pkg::MAX_WIDTH_DEF);
    h  = span_of(height_reg, rgbnv_pkg::MAX_HEIGHT_DEF);
    beat.luma         = 8'(clip_byte(16 + ((47 * r + 157 * gr + 16 * b + 128) >>> 8)));
    cb                = clip_byte((-26 * r - 87 * gr + 112 * b + 32896) >>> 8);
    cr                = clip_byte((112 * r - 102 * gr - 10 * b + 32896) >>> 8);
    beat.chroma_valid = 1'b0;
    beat.chroma_u     = '0;
    beat.chroma_v     = '0;
    if (column_pos % 2 == 0) begin
      left_chroma = {8'(cr), 8'(cb)};
    end else begin
      u_sum = int'(left_chroma[7:0]) + cb;
      v_sum = int'(left_chroma[15:8]) + cr;
      if (row_pos % 2 == 0) begin
        pair_sums[column_pos / 2] = {9'(v_sum), 9'(u_sum)};
      end else begin
        sums  = pair_sums[column_pos / 2];
        u_sum += int'(sums[8:0]);
        v_sum += int'(sums[17:9]);
        beat.chroma_valid = 1'b1;
        beat.chroma_u     = 8'(u_sum >> 2);
        beat.chroma_v     = 8'(v_sum >> 2);
      end
    end
    beat.frame_end = (column_pos + 1 >= w) && (row_pos + 1 >= h);
    if (column_pos + 1 >= w) begin
      column_pos = 0;
      row_pos    = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      column_pos++;
    end
    return beat;
  endfunction

  function automatic void check_field(string field, logic [rgbnv_pkg::CHAN_W-1:0] want,
                                      logic [rgbnv_pkg::CHAN_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : watch
    nv12_beat_t want;
    if (rst) begin
      byte_swap   = 1'b0;
      width_reg   = rgbnv_pkg::FRAME_SIZE_RESET;
      height_reg  = rgbnv_pkg::FRAME_SIZE_RESET;
      column_pos  = 0;
      row_pos     = 0;
      left_chroma = '0;
      expected_pixels.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          rgbnv_pkg::REG_BYTE_ORDER:   byte_swap  = cfg_data[0];
          rgbnv_pkg::REG_FRAME_WIDTH:  width_reg  = cfg_data;
          rgbnv_pkg::REG_FRAME_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected output beat: luma %0d", luma);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("luma", want.luma, luma);
          check_field("chroma_valid", want.chroma_valid, chroma_valid);
          check_field("chroma_u", want.chroma_u, chroma_u);
          check_field("chroma_v", want.chroma_v, chroma_v);
          check_field("frame_end", want.frame_end, frame_end);
        end
      end
      if (in_valid && !in_stall)
        expected_pixels.push_back(convert_pixel(channel_a, channel_b, channel_c));
    end
    pending_beats <= expected_pixels.size();
    fail_count    <= mismatches;
  end

endmodule

FILE: verif/rgb_to_nv12_converter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_nv12_converter_test
// drives pixel beats and register writes into the converter under random
// sender gaps and receiver stalls; a checker beside the block predicts and
// compares every output beat, and this module gives the verdict
// ----------------------------------------------------------------------------
module rgb_to_nv12_converter_test;

  localparam int SIZE_W        = rgbnv_pkg::SIZE_W;
  localparam int RANDOM_PIXELS = 500;
  localparam int CALM_TAIL     = 60;   // last random beats run with no gaps or stalls
  localparam int LINE_PAIRS    = rgbnv_pkg::MAX_WIDTH_DEF / 2;

  // black, white, primaries, alternating bit patterns, magenta
  localparam logic [23:0] TEST_COLORS [8] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hAA55AA, 24'h55AA55, 24'hFF00FF
  };

  logic                              clk;
  logic                              rst;
  logic                              cfg_write;
  logic [rgbnv_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]                 cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [rgbnv_pkg::CHAN_W-1:0]      channel_a;
  logic [rgbnv_pkg::CHAN_W-1:0]      channel_b;
  logic [rgbnv_pkg::CHAN_W-1:0]      channel_c;
  logic                              out_valid;
  logic                              out_stall;
  logic [rgbnv_pkg::CHAN_W-1:0]      luma;
  logic                              chroma_valid;
  logic [rgbnv_pkg::CHAN_W-1:0]      chroma_u;
  logic [rgbnv_pkg::CHAN_W-1:0]      chroma_v;
  logic                              frame_end;
  int                                pending_beats;
  int                                fail_count;

  // stimulus-side knobs
  bit calm;
  bit idling_on;

  // raster position as the block sees it, kept so that a width change never
  // makes an odd row read a line store pair that no even row has written
  logic [SIZE_W-1:0] width_now;
  int                span_w;
  int                span_h;
  int                col_pos;
  int                row_pos;
  bit                pair_written [LINE_PAIRS];

  rgb_to_nv12_converter u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .channel_a    (channel_a),
    .channel_b    (channel_b),
    .channel_c    (channel_c),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .luma         (luma),
    .chroma_valid (chroma_valid),
    .chroma_u     (chroma_u),
    .chroma_v     (chroma_v),
    .frame_end    (frame_end)
  );

  nv12_stream_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .channel_a     (channel_a),
    .channel_b     (channel_b),
    .channel_c     (channel_c),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .luma          (luma),
    .chroma_valid  (chroma_valid),
    .chroma_u      (chroma_u),
    .chroma_v      (chroma_v),
    .frame_end     (frame_end),
    .pending_beats (pending_beats),
    .fail_count    (fail_count)
  );

  // 125 MHz clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver side: random stall bursts
  initial begin : receiver_stalls
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling_on && !calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // same clamp and even rounding that the block applies to a size register
  function automatic int span_of(logic [SIZE_W-1:0] value, int limit);
    int s;
    s = value;
    if (s > limit) s = limit;
    if (s < 2) s = 2;
    return s & ~1;
  endfunction

  // on an odd row, every odd column still to come under width w reads a pair
  function automatic bit width_is_safe(int w);
    int final_col;
    if (row_pos % 2 == 0) return 1'b1;
    final_col = (col_pos >= w - 1) ? col_pos : w - 1;
    for (int x = col_pos; x <= final_col; x++)
      if (x % 2 == 1 && !pair_written[x / 2]) return 1'b0;
    return 1'b1;
  endfunction

  // mostly small frames, now and then an extreme or out-of-range value
  function automatic logic [SIZE_W-1:0] pick_size(int upto);
    if ($urandom_range(0, 9) != 0) return SIZE_W'($urandom_range(2, upto));
    case ($urandom_range(0, 4))
      0:       return SIZE_W'(0);
      1:       return SIZE_W'(1);
      2:       return SIZE_W'(2048);
      3:       return SIZE_W'(4095);
      default: return SIZE_W'($urandom_range(2049, 4094));
    endcase
  endfunction

  // all three registers, one per cycle; only called with the block idle
  task automatic configure(logic order, logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    cfg_write <= 1'b1;
    cfg_index <= rgbnv_pkg::REG_BYTE_ORDER;
    cfg_data  <= SIZE_W'(order);
    @(posedge clk);
    cfg_index <= rgbnv_pkg::REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= rgbnv_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_write <= 1'b0;
    width_now = w;
    span_w    = span_of(w, rgbnv_pkg::MAX_WIDTH_DEF);
    span_h    = span_of(h, rgbnv_pkg::MAX_HEIGHT_DEF);
  endtask

  // one pixel beat, with an optional gap in front; returns on the accepting edge
  task automatic put_pixel(logic [23:0] rgb);
    if (idling_on && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {channel_a, channel_b, channel_c} <= rgb;
    do @(posedge clk); while (in_stall);
    // even rows fill the line store at odd columns
    if (col_pos % 2 == 1 && row_pos % 2 == 0) pair_written[col_pos / 2] = 1'b1;
    if (col_pos + 1 >= span_w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= span_h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endtask

  // wait until every predicted beat has come out, plus the pipeline depth
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int                sent;
    int                burst;
    logic [23:0]       rgb;
    logic [SIZE_W-1:0] w_pick;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    channel_a <= '0;
    channel_b <= '0;
    channel_c <= '0;
    cfg_write <= 1'b0;
    cfg_index <= rgbnv_pkg::REG_BYTE_ORDER;
    cfg_data  <= '0;
    calm      = 1'b0;
    idling_on = 1'b1;
    width_now = rgbnv_pkg::FRAME_SIZE_RESET;
    span_w    = rgbnv_pkg::MAX_WIDTH_DEF;
    span_h    = rgbnv_pkg::MAX_HEIGHT_DEF;
    col_pos   = 0;
    row_pos   = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // one 4x2 frame of extreme colors in rgb order
    configure(1'b0, SIZE_W'(4), SIZE_W'(2));
    foreach (TEST_COLORS[i]) put_pixel(TEST_COLORS[i]);
    drain();

    // sizes below the floor give 2x2 frames; bgr order
    configure(1'b1, SIZE_W'(1), SIZE_W'(0));
    foreach (TEST_COLORS[i]) put_pixel(TEST_COLORS[i]);
    drain();

    // width above the ceiling clamps to the maximum, part of a long row
    configure(1'b0, SIZE_W'(4095), SIZE_W'(2048));
    repeat (6) put_pixel(24'($urandom));
    drain();

    // odd sizes round down; the column is already past the new row end and wraps
    configure(1'b1, SIZE_W'(5), SIZE_W'(3));
    repeat (3) put_pixel(24'($urandom));
    drain();

    // random phases: new settings each time, counters carried across
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      w_pick = pick_size(16);
      if (!width_is_safe(span_of(w_pick, rgbnv_pkg::MAX_WIDTH_DEF))) w_pick = width_now;
      idling_on = ($urandom_range(0, 3) != 0);
      configure(1'($urandom_range(0, 1)), w_pick, pick_size(8));
      burst = $urandom_range(8, 60);
      if (burst > RANDOM_PIXELS - sent) burst = RANDOM_PIXELS - sent;
      repeat (burst) begin
        calm = (sent >= RANDOM_PIXELS - CALM_TAIL);
        rgb  = 24'($urandom);
        // pull single channels to the rails now and then
        if ($urandom_range(0, 7) == 0) rgb[23:16] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0) rgb[15:8]  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 7) == 0) rgb[7:0]   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        put_pixel(rgb);
        sent++;
      end
      drain();
    end

    // catch any stray beat after the last expected one
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rgbnv_pkg.sv
rtl/rgbnv_line_store.sv
rtl/rgbnv_raster.sv
rtl/rgb_to_nv12_converter.sv
verif/nv12_stream_checker.sv
verif/rgb_to_nv12_converter_test.sv
